/* rtl/core/gwwl_pkg.sv */
// ----------------------------------------------------------------------------
// gwwl_pkg
// Shared types, widths and codes of the greedy word-wrap layout block.
// ----------------------------------------------------------------------------
package gwwl_pkg;

    localparam int MAX_WORD = 32;
    localparam int IDX_W    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int CNT_W    = $clog2(MAX_WORD + 1);
    localparam int ADDR_W   = IDX_W + 1;
    localparam int NUM_REGS = 5;
    localparam int PADDR_W  = $clog2(NUM_REGS * 4);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [17:0]       adv_t;
    typedef logic [23:0]       w24_t;
    typedef logic [24:0]       w25_t;

    localparam cnt_t WORD_FULL = cnt_t'(MAX_WORD);
    localparam w24_t MAX24     = 24'hFFFFFF;
    localparam w25_t MAXX      = 25'h1FFFFFF;
    localparam w25_t MINY      = 25'h1000000;

    typedef enum logic [1:0] {
        OP_LETTER  = 2'd0,
        OP_SPACE   = 2'd1,
        OP_NEWLINE = 2'd2,
        OP_END     = 2'd3
    } op_t;

    localparam logic [2:0] REG_BOX_WIDTH    = 3'd0;
    localparam logic [2:0] REG_TEXT_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_LETTER_SPACE = 3'd2;
    localparam logic [2:0] REG_WORD_SPACE   = 3'd3;
    localparam logic [2:0] REG_LINE_SPACE   = 3'd4;

    typedef struct packed {
        logic [23:0] box_width;
        logic [15:0] text_height;
        logic [15:0] letter_space;
        logic [15:0] word_space;
        logic [15:0] line_space;
    } cfg_t;

    typedef struct packed {
        op_t  op;
        cnt_t count;
        w24_t width;
        logic lost;
        logic bank;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic [7:0] ch;
        adv_t       adv;
    } mem_word_t;

    typedef struct packed {
        logic      en;
        addr_t     addr;
        mem_word_t data;
    } mem_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        w24_t        pos_x;
        w25_t        pos_y;
        w24_t        box_height;
        logic        overflow;
        logic        last;
    } res_t;

endpackage

/* rtl/core/gwwl_cfg.sv */
// ----------------------------------------------------------------------------
// gwwl_cfg
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module gwwl_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gwwl_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output gwwl_pkg::cfg_t                cfg
);

    gwwl_pkg::cfg_t cfg_reg;
    gwwl_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                gwwl_pkg::REG_BOX_WIDTH:    cfg_next.box_width    = pwdata[23:0];
                gwwl_pkg::REG_TEXT_HEIGHT:  cfg_next.text_height  = pwdata[15:0];
                gwwl_pkg::REG_LETTER_SPACE: cfg_next.letter_space = pwdata[15:0];
                gwwl_pkg::REG_WORD_SPACE:   cfg_next.word_space   = pwdata[15:0];
                gwwl_pkg::REG_LINE_SPACE:   cfg_next.line_space   = pwdata[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            gwwl_pkg::REG_BOX_WIDTH:    prdata = {8'd0, cfg_reg.box_width};
            gwwl_pkg::REG_TEXT_HEIGHT:  prdata = {16'd0, cfg_reg.text_height};
            gwwl_pkg::REG_LETTER_SPACE: prdata = {16'd0, cfg_reg.letter_space};
            gwwl_pkg::REG_WORD_SPACE:   prdata = {16'd0, cfg_reg.word_space};
            gwwl_pkg::REG_LINE_SPACE:   prdata = {16'd0, cfg_reg.line_space};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_width    <= 24'd25600;
            cfg_reg.text_height  <= 16'd1280;
            cfg_reg.letter_space <= 16'd0;
            cfg_reg.word_space   <= 16'd0;
            cfg_reg.line_space   <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/gwwl_front.sv */
// ----------------------------------------------------------------------------
// gwwl_front
// Accepts items, scales letter widths, fills the word banks and queues
// one command per delimiter for the back end.
// ----------------------------------------------------------------------------
module gwwl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [1:0]        op,
    input  logic [7:0]        char_code,
    input  logic [9:0]        glyph_width,
    output logic              full,
    input  logic [15:0]       text_height,
    input  logic [15:0]       letter_space,
    output logic              cmd_valid,
    output gwwl_pkg::cmd_t    cmd,
    input  logic              cmd_pop,
    input  gwwl_pkg::rel_t    rel,
    output gwwl_pkg::mem_wr_t mem_wr
);

    logic                  stg_valid_reg, stg_valid_next;
    gwwl_pkg::op_t         stg_op_reg;
    logic [7:0]            stg_char_reg;
    gwwl_pkg::adv_t        stg_adv_reg;

    gwwl_pkg::cnt_t        cnt_reg, cnt_next;
    gwwl_pkg::w24_t        total_reg, total_next;
    logic                  lost_reg, lost_next;
    logic                  bank_reg, bank_next;
    logic [1:0]            held_reg, held_next;
    logic                  prev_nl_reg, prev_nl_next;

    gwwl_pkg::cmd_t        q_mem_reg [0:1];
    logic                  q_wr_reg, q_wr_next;
    logic                  q_rd_reg, q_rd_next;
    logic [1:0]            q_cnt_reg, q_cnt_next;

    logic                  is_letter;
    logic                  q_full;
    logic                  stg_go;
    logic                  take;
    logic                  cmd_push;
    logic [25:0]           prod;
    logic [24:0]           sum_tot;
    logic [24:0]           sum_ww;
    gwwl_pkg::w24_t        tot_sat;
    gwwl_pkg::w24_t        ww_sp;
    gwwl_pkg::cmd_t        new_cmd;

    always_comb
    begin
        is_letter = (stg_op_reg == gwwl_pkg::OP_LETTER);
        q_full    = (q_cnt_reg == 2'd2);
        stg_go    = stg_valid_reg && (is_letter ? !held_reg[bank_reg] : !q_full);
        full      = stg_valid_reg && !stg_go;
        take      = push && !full;
        cmd_push  = stg_go && !is_letter;
        prod      = {16'd0, glyph_width} * {10'd0, text_height};

        sum_tot = {1'b0, total_reg} + {7'd0, stg_adv_reg};
        tot_sat = sum_tot[24] ? gwwl_pkg::MAX24 : sum_tot[23:0];
        sum_ww  = {1'b0, total_reg} + {9'd0, letter_space};
        ww_sp   = sum_ww[24] ? gwwl_pkg::MAX24 : sum_ww[23:0];

        new_cmd.op    = stg_op_reg;
        new_cmd.count = cnt_reg;
        new_cmd.width = (stg_op_reg == gwwl_pkg::OP_SPACE) ? ww_sp : total_reg;
        new_cmd.lost  = lost_reg;
        new_cmd.bank  = bank_reg;
        new_cmd.flush = (stg_op_reg == gwwl_pkg::OP_END) ? !prev_nl_reg : 1'b1;

        mem_wr.en        = 1'b0;
        mem_wr.addr      = {bank_reg, cnt_reg[gwwl_pkg::IDX_W-1:0]};
        mem_wr.data.ch   = stg_char_reg;
        mem_wr.data.adv  = stg_adv_reg;

        stg_valid_next = take || (stg_valid_reg && !stg_go);
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        lost_next      = lost_reg;
        bank_next      = bank_reg;
        prev_nl_next   = prev_nl_reg;
        held_next      = held_reg;

        if (rel.valid)
        begin
            held_next[rel.bank] = 1'b0;
        end

        if (stg_go)
        begin
            if (is_letter)
            begin
                if (cnt_reg < gwwl_pkg::WORD_FULL)
                begin
                    mem_wr.en  = 1'b1;
                    cnt_next   = cnt_reg + gwwl_pkg::cnt_t'(1);
                    total_next = tot_sat;
                end
                else
                begin
                    lost_next = 1'b1;
                end
                prev_nl_next = 1'b0;
            end
            else
            begin
                cnt_next     = '0;
                total_next   = '0;
                lost_next    = 1'b0;
                prev_nl_next = (stg_op_reg == gwwl_pkg::OP_NEWLINE);
                if (cnt_reg != '0)
                begin
                    held_next[bank_reg] = 1'b1;
                    bank_next           = !bank_reg;
                end
            end
        end

        q_wr_next  = cmd_push ? !q_wr_reg : q_wr_reg;
        q_rd_next  = cmd_pop ? !q_rd_reg : q_rd_reg;
        q_cnt_next = q_cnt_reg + {1'b0, cmd_push} - {1'b0, cmd_pop};

        cmd_valid = (q_cnt_reg != 2'd0);
        cmd       = q_mem_reg[q_rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stg_op_reg   <= gwwl_pkg::op_t'(op);
            stg_char_reg <= char_code;
            stg_adv_reg  <= prod[25:8];
        end
        if (cmd_push)
        begin
            q_mem_reg[q_wr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            lost_reg      <= 1'b0;
            bank_reg      <= 1'b0;
            held_reg      <= 2'b00;
            prev_nl_reg   <= 1'b0;
            q_wr_reg      <= 1'b0;
            q_rd_reg      <= 1'b0;
            q_cnt_reg     <= 2'd0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            lost_reg      <= lost_next;
            bank_reg      <= bank_next;
            held_reg      <= held_next;
            prev_nl_reg   <= prev_nl_next;
            q_wr_reg      <= q_wr_next;
            q_rd_reg      <= q_rd_next;
            q_cnt_reg     <= q_cnt_next;
        end
    end

endmodule

/* rtl/core/gwwl_back.sv */
// ----------------------------------------------------------------------------
// gwwl_back
// Owns the cursor and the word banks; wraps, places letters, applies the
// delimiter and queues results for the output side.
// ----------------------------------------------------------------------------
module gwwl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  gwwl_pkg::cfg_t    cfg,
    input  logic              cmd_valid,
    input  gwwl_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output gwwl_pkg::rel_t    rel,
    input  gwwl_pkg::mem_wr_t mem_wr,
    output gwwl_pkg::res_t    res,
    output logic              empty,
    input  logic              pop
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRAP  = 6'b000010,
        S_READ  = 6'b000100,
        S_PLACE = 6'b001000,
        S_POST  = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    gwwl_pkg::cmd_t         cmd_reg, cmd_next;
    gwwl_pkg::idx_t         idx_reg, idx_next;
    gwwl_pkg::w25_t         x_reg, x_next;
    gwwl_pkg::w25_t         y_reg, y_next;

    gwwl_pkg::mem_word_t    mem [0:(2**gwwl_pkg::ADDR_W)-1];
    gwwl_pkg::mem_word_t    rd_data_reg;
    gwwl_pkg::addr_t        rd_addr;

    gwwl_pkg::res_t         rq_mem_reg [0:1];
    logic                   rq_wr_reg, rq_wr_next;
    logic                   rq_rd_reg, rq_rd_next;
    logic [1:0]             rq_cnt_reg, rq_cnt_next;
    logic                   rq_full;
    logic                   rq_push;
    logic                   rq_pop;
    gwwl_pkg::res_t         rq_in;

    logic [16:0]            pitch;
    logic [25:0]            y_nl_wide;
    gwwl_pkg::w25_t         y_nl;
    logic [25:0]            xw;
    logic                   wrap;
    logic [18:0]            step;
    logic [25:0]            xs;
    gwwl_pkg::w25_t         x_adv;
    logic [25:0]            xsp;
    gwwl_pkg::w25_t         x_sp;
    gwwl_pkg::w24_t         px;
    gwwl_pkg::w25_t         neg_y;
    gwwl_pkg::w24_t         height;
    logic                   last_letter;

    always_comb
    begin
        pitch     = {1'b0, cfg.text_height} + {1'b0, cfg.line_space};
        y_nl_wide = {y_reg[24], y_reg} - {9'd0, pitch};
        y_nl      = (y_nl_wide[25] != y_nl_wide[24]) ? gwwl_pkg::MINY : y_nl_wide[24:0];

        xw   = {1'b0, x_reg} + {2'd0, cmd_reg.width};
        wrap = (xw > {2'd0, cfg.box_width}) && (cmd_reg.width <= cfg.box_width);

        step  = {1'b0, rd_data_reg.adv} + {3'd0, cfg.letter_space};
        xs    = {1'b0, x_reg} + {7'd0, step};
        x_adv = xs[25] ? gwwl_pkg::MAXX : xs[24:0];
        xsp   = {1'b0, x_reg} + {10'd0, cfg.word_space};
        x_sp  = xsp[25] ? gwwl_pkg::MAXX : xsp[24:0];
        px    = x_reg[24] ? gwwl_pkg::MAX24 : x_reg[23:0];

        neg_y  = 25'd0 - y_reg;
        height = neg_y[24] ? gwwl_pkg::MAX24 : neg_y[23:0];

        last_letter = ((gwwl_pkg::cnt_t'(idx_reg) + gwwl_pkg::cnt_t'(1)) == cmd_reg.count);
        rd_addr     = {cmd_reg.bank, idx_reg};
        rq_full     = (rq_cnt_reg == 2'd2);
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        cmd_pop    = 1'b0;
        rel.valid  = 1'b0;
        rel.bank   = cmd_reg.bank;
        rq_push    = 1'b0;

        rq_in.kind       = 1'b0;
        rq_in.ch         = rd_data_reg.ch;
        rq_in.pos_x      = px;
        rq_in.pos_y      = y_reg;
        rq_in.box_height = '0;
        rq_in.overflow   = cmd_reg.lost;
        rq_in.last       = last_letter && (cmd_reg.op != gwwl_pkg::OP_END);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    cmd_pop    = 1'b1;
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                idx_next = '0;
                if ((cmd_reg.op == gwwl_pkg::OP_END) && !cmd_reg.flush)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    if (wrap)
                    begin
                        x_next = '0;
                        y_next = y_nl;
                    end
                    state_next = (cmd_reg.count != '0) ? S_READ : S_POST;
                end
            end
            S_READ:
            begin
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                if (!rq_full)
                begin
                    rq_push    = 1'b1;
                    x_next     = x_adv;
                    idx_next   = idx_reg + gwwl_pkg::idx_t'(1);
                    state_next = last_letter ? S_POST : S_READ;
                end
            end
            S_POST:
            begin
                rel.valid = (cmd_reg.count != '0);
                unique case (cmd_reg.op)
                    gwwl_pkg::OP_SPACE:
                    begin
                        x_next = x_sp;
                    end
                    gwwl_pkg::OP_NEWLINE, gwwl_pkg::OP_END:
                    begin
                        x_next = '0;
                        y_next = y_nl;
                    end
                    default:
                    begin
                        x_next = x_reg;
                    end
                endcase
                state_next = (cmd_reg.op == gwwl_pkg::OP_END) ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                rq_in.kind       = 1'b1;
                rq_in.ch         = '0;
                rq_in.pos_x      = '0;
                rq_in.pos_y      = '0;
                rq_in.box_height = height;
                rq_in.overflow   = 1'b0;
                rq_in.last       = 1'b1;
                if (!rq_full)
                begin
                    rq_push    = 1'b1;
                    x_next     = '0;
                    y_next     = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        empty       = (rq_cnt_reg == 2'd0);
        rq_pop      = pop && !empty;
        res         = rq_mem_reg[rq_rd_reg];
        rq_wr_next  = rq_push ? !rq_wr_reg : rq_wr_reg;
        rq_rd_next  = rq_pop ? !rq_rd_reg : rq_rd_reg;
        rq_cnt_next = rq_cnt_reg + {1'b0, rq_push} - {1'b0, rq_pop};
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        rd_data_reg <= mem[rd_addr];
        if (rq_push)
        begin
            rq_mem_reg[rq_wr_reg] <= rq_in;
        end
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            x_reg      <= '0;
            y_reg      <= '0;
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            rq_wr_reg  <= rq_wr_next;
            rq_rd_reg  <= rq_rd_next;
            rq_cnt_reg <= rq_cnt_next;
        end
    end

endmodule

/* rtl/core/greedy_word_wrap_layout.sv */
// ----------------------------------------------------------------------------
// greedy_word_wrap_layout
// Greedy word-wrap layout of a text stream, Q16.8 fixed point.
//
//   channel   direction   handshake          payload
//   input     in          push / full        op, char_code, glyph_width
//   result    out         empty / pop        kind, out_char, pos_x, pos_y,
//                                            box_height, overflow, last
//   config    in          APB psel/penable   paddr, pwdata, prdata
//
// The front end stages a letter (width multiply), then writes it to its bank.
// The back end passes a delimiter through idle, wrap and post; each placed
// letter is read from its bank, then placed once the result queue has room;
// an end-of-text result adds fin, entered from wrap right after a newline.
// Two word banks let the front fill one word while the back places the other;
// a 2-deep command queue and a 2-deep result queue decouple both sides.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module greedy_word_wrap_layout (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   op,
    input  logic [7:0]                   char_code,
    input  logic [9:0]                   glyph_width,
    output logic                         empty,
    input  logic                         pop,
    output logic                         kind,
    output logic [7:0]                   out_char,
    output logic [23:0]                  pos_x,
    output logic signed [24:0]           pos_y,
    output logic [23:0]                  box_height,
    output logic                         overflow,
    output logic                         last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gwwl_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    gwwl_pkg::cfg_t    cfg;
    logic              cmd_valid;
    gwwl_pkg::cmd_t    cmd;
    logic              cmd_pop;
    gwwl_pkg::rel_t    rel;
    gwwl_pkg::mem_wr_t mem_wr;
    gwwl_pkg::res_t    res;

    gwwl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gwwl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .op           (op),
        .char_code    (char_code),
        .glyph_width  (glyph_width),
        .full         (full),
        .text_height  (cfg.text_height),
        .letter_space (cfg.letter_space),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .rel          (rel),
        .mem_wr       (mem_wr)
    );

    gwwl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rel       (rel),
        .mem_wr    (mem_wr),
        .res       (res),
        .empty     (empty),
        .pop       (pop)
    );

    assign kind       = res.kind;
    assign out_char   = res.ch;
    assign pos_x      = res.pos_x;
    assign pos_y      = $signed(res.pos_y);
    assign box_height = res.box_height;
    assign overflow   = res.overflow;
    assign last       = res.last;

endmodule
